// ===== src/btt_pkg.sv =====
// ---------------------------------------------------------------------------
// btt_pkg: shared types and constants for the bearing-to-target core
// Widths of the CORDIC datapath, angle table and fixed bearing values.
// ---------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

    localparam int unsigned COORD_W        = 24;
    localparam int unsigned DIFF_W         = COORD_W + 1;
    localparam int unsigned PRESCALE_SH    = 24;
    localparam int unsigned VEC_W          = 52;
    localparam int unsigned Z_W            = 26;
    localparam int unsigned BEARING_W      = 25;
    localparam int unsigned ATAN_W         = 22;
    localparam int unsigned ATAN_ENTRIES   = 24;
    localparam int unsigned BTT_ITERATIONS = 16;

    localparam logic [BEARING_W-1:0] DEG_0   = 25'd0;
    localparam logic [BEARING_W-1:0] DEG_90  = 25'd5898240;
    localparam logic [BEARING_W-1:0] DEG_180 = 25'd11796480;
    localparam logic [BEARING_W-1:0] DEG_270 = 25'd17694720;
    localparam logic [BEARING_W-1:0] DEG_360 = 25'd23592960;

    // forced results for vectors lying on an axis
    typedef enum logic [2:0] {
        SPEC_NONE,
        SPEC_0,
        SPEC_90,
        SPEC_180,
        SPEC_270
    } btt_spec_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    rear;
        btt_spec_t               spec;
    } btt_vec_t;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== src/btt_prep.sv =====
// ---------------------------------------------------------------------------
// btt_prep: difference vector and quadrant fold
// Forms dx and dy, folds the rear half plane by 180 degrees, flags axis
// cases and scales the vector into the CORDIC word.
// ---------------------------------------------------------------------------
`default_nettype none

module btt_prep
    import btt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] current_x,
    input  wire logic signed [COORD_W-1:0] current_y,
    input  wire logic signed [COORD_W-1:0] target_x,
    input  wire logic signed [COORD_W-1:0] target_y,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output btt_vec_t                       out_vec
);

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx_neg;
    logic signed [DIFF_W-1:0] dy_neg;
    logic signed [DIFF_W-1:0] fold_x;
    logic signed [DIFF_W-1:0] fold_y;
    logic                     rear;
    btt_spec_t                spec;
    btt_vec_t                 vec_next;
    btt_vec_t                 vec_reg;
    logic                     valid_reg;

    // negated differences computed in parallel so the fold is only a mux
    assign dx     = {target_x[COORD_W-1], target_x} - {current_x[COORD_W-1], current_x};
    assign dy     = {target_y[COORD_W-1], target_y} - {current_y[COORD_W-1], current_y};
    assign dx_neg = {current_x[COORD_W-1], current_x} - {target_x[COORD_W-1], target_x};
    assign dy_neg = {current_y[COORD_W-1], current_y} - {target_y[COORD_W-1], target_y};

    assign rear   = dy[DIFF_W-1];
    assign fold_x = rear ? dy_neg : dy;
    assign fold_y = rear ? dx_neg : dx;

    always_comb
    begin
        if (dx == '0)
        begin
            spec = rear ? SPEC_180 : SPEC_0;
        end
        else if (dy == '0)
        begin
            spec = dx[DIFF_W-1] ? SPEC_270 : SPEC_90;
        end
        else
        begin
            spec = SPEC_NONE;
        end
    end

    always_comb
    begin
        vec_next.x    = {{(VEC_W-DIFF_W-PRESCALE_SH){fold_x[DIFF_W-1]}}, fold_x,
                         {PRESCALE_SH{1'b0}}};
        vec_next.y    = {{(VEC_W-DIFF_W-PRESCALE_SH){fold_y[DIFF_W-1]}}, fold_y,
                         {PRESCALE_SH{1'b0}}};
        vec_next.z    = '0;
        vec_next.rear = rear;
        vec_next.spec = spec;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== src/btt_cell.sv =====
// ---------------------------------------------------------------------------
// btt_cell: one CORDIC vectoring micro-rotation
// Rotates the vector toward the X axis by atan(2^-STAGE) and accumulates
// the angle; one beat per cycle with local stall.
// ---------------------------------------------------------------------------
`default_nettype none

module btt_cell
    import btt_pkg::*;
#(
    parameter int unsigned STAGE = 0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire btt_vec_t in_vec,
    output logic          out_valid,
    input  wire logic     out_ready,
    output btt_vec_t      out_vec
);

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(atan_q16(5'(STAGE)));

    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] x_sh;
    logic signed [VEC_W-1:0] y_sh;
    logic                    y_neg;
    btt_vec_t                vec_next;
    btt_vec_t                vec_reg;
    logic                    valid_reg;

    assign x_in  = in_vec.x;
    assign y_in  = in_vec.y;
    assign x_sh  = x_in >>> STAGE;
    assign y_sh  = y_in >>> STAGE;
    assign y_neg = y_in[VEC_W-1];

    always_comb
    begin
        vec_next = in_vec;
        if (y_neg)
        begin
            vec_next.x = x_in - y_sh;
            vec_next.y = y_in + x_sh;
            vec_next.z = in_vec.z - ANGLE;
        end
        else
        begin
            vec_next.x = x_in + y_sh;
            vec_next.y = y_in - x_sh;
            vec_next.z = in_vec.z + ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== src/btt_post.sv =====
// ---------------------------------------------------------------------------
// btt_post: bearing assembly and output register
// Adds the half-plane base, wraps into [0, 360) and applies axis results.
// Two register stages; the second is the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module btt_post
    import btt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire btt_vec_t              in_vec,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BEARING_W-1:0]       bearing
);

    localparam logic signed [Z_W-1:0] Z_180 = Z_W'(DEG_180);
    localparam logic signed [Z_W-1:0] Z_360 = Z_W'(DEG_360);

    logic signed [Z_W-1:0]  sum_next;
    logic signed [Z_W-1:0]  sum_reg;
    btt_spec_t              spec_reg;
    logic                   sum_valid_reg;
    logic                   sum_ready;
    logic signed [Z_W-1:0]  wrap;
    logic [BEARING_W-1:0]   bearing_next;
    logic [BEARING_W-1:0]   bearing_reg;
    logic                   out_valid_reg;

    assign sum_next = in_vec.z + (in_vec.rear ? Z_180 : Z_W'(0));

    assign in_ready  = !sum_valid_reg || sum_ready;
    assign sum_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (sum_reg < 0)
        begin
            wrap = sum_reg + Z_360;
        end
        else if (sum_reg >= Z_360)
        begin
            wrap = sum_reg - Z_360;
        end
        else
        begin
            wrap = sum_reg;
        end
    end

    always_comb
    begin
        case (spec_reg)
            SPEC_0:    bearing_next = DEG_0;
            SPEC_90:   bearing_next = DEG_90;
            SPEC_180:  bearing_next = DEG_180;
            SPEC_270:  bearing_next = DEG_270;
            default:   bearing_next = wrap[BEARING_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg  <= sum_next;
            spec_reg <= in_vec.spec;
        end
        if (sum_valid_reg && sum_ready)
        begin
            bearing_reg <= bearing_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bearing   = bearing_reg;

endmodule

`default_nettype wire

// ===== src/bearing_to_target_core.sv =====
// ---------------------------------------------------------------------------
// bearing_to_target_core: compass bearing atan2(dx, dy) by CORDIC
// Throughput: one beat per cycle without back-pressure; one prep stage, one cell
// per iteration (at most ATAN_ENTRIES) and two output stages, each holding one beat.
// Every stage stalls locally, so bubbles are squeezed out under back-pressure.
// Reset clears all valid flags; datapath registers are not reset.
// ---------------------------------------------------------------------------
`default_nettype none

module bearing_to_target_core
    import btt_pkg::*;
#(
    parameter int unsigned ITERATIONS = BTT_ITERATIONS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] current_x,
    input  wire logic signed [COORD_W-1:0] current_y,
    input  wire logic signed [COORD_W-1:0] target_x,
    input  wire logic signed [COORD_W-1:0] target_y,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [BEARING_W-1:0]           bearing
);

    localparam int unsigned STAGES =
        (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

    btt_vec_t          chain_vec   [STAGES+1];
    logic [STAGES:0]   chain_valid;
    logic [STAGES:0]   chain_ready;

    btt_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .current_x (current_x),
        .current_y (current_y),
        .target_x  (target_x),
        .target_y  (target_y),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        btt_cell #(
            .STAGE (i)
        ) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    btt_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[STAGES]),
        .in_ready  (chain_ready[STAGES]),
        .in_vec    (chain_vec[STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bearing   (bearing)
    );

    // an empty output register must never block the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bearing < DEG_360))
        else $error("bearing out of range");

    a_accept_enters_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> chain_valid[0])
        else $error("accepted beat lost at prep stage");

endmodule

`default_nettype wire
